// ===== sv/tgard_pkg.sv =====
`default_nettype none

package tgard_pkg;

    // Default palette size, handed to the top level parameter
    localparam int PALETTE_DEPTH_DEF = 256;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input item types
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_STREAM  = 1'b1;

    // Configuration as seen by the front end
    typedef struct packed {
        logic        rle_enable;
        logic [1:0]  depth_mode;
        logic [31:0] pixel_total;
    } cfg_t;

    typedef enum logic {
        ENTRY_PAL_WRITE,
        ENTRY_PIXEL
    } entry_kind_t;

    // One queued command for the back end
    typedef struct packed {
        entry_kind_t kind;
        logic        use_pal;    // colour comes from the palette
        logic [7:0]  index;      // palette address (write or lookup)
        logic [23:0] rgb;        // {red, green, blue}
        logic [7:0]  alpha;
        logic [7:0]  count;
        logic        image_end;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/tgard_in_if.sv =====
`default_nettype none

interface tgard_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
    logic [7:0] stream_byte;

    modport source (
        output valid, req_type, pal_index, pal_red, pal_green, pal_blue, stream_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, pal_index, pal_red, pal_green, pal_blue, stream_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/tgard_out_if.sv =====
`default_nettype none

interface tgard_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [7:0] repeat_count;
    logic       image_end;

    modport source (
        output valid, out_index, out_red, out_green, out_blue, out_alpha,
               repeat_count, image_end,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_red, out_green, out_blue, out_alpha,
               repeat_count, image_end,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/tgard_front.sv =====
`default_nettype none

// Front end: takes items, tracks packet and pixel state, queues commands
module tgard_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tgard_pkg::cfg_t  cfg,
    tgard_in_if.sink              req,
    input  wire logic             q_full,
    output logic                  push,
    output tgard_pkg::entry_t     push_entry
);

    localparam logic [1:0] DEPTH_INDEX8 = 2'd0;
    localparam logic [1:0] DEPTH_BGR24  = 2'd1;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    logic        expect_header_reg, expect_header_next;
    logic        run_flag_reg, run_flag_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [23:0] pixel_bytes_reg, pixel_bytes_next;
    logic [31:0] pixels_left_reg, pixels_left_next;

    assign req.ready = !q_full;

    // Per-byte state update
    always_comb
    begin
        logic [7:0]  b;
        logic [1:0]  last_pos;
        logic [31:0] shifted;
        logic [7:0]  cnt;

        b        = req.stream_byte;
        last_pos = 2'd3;
        shifted  = '0;
        cnt      = 8'd1;

        expect_header_next = expect_header_reg;
        run_flag_next      = run_flag_reg;
        packet_left_next   = packet_left_reg;
        byte_pos_next      = byte_pos_reg;
        pixel_bytes_next   = pixel_bytes_reg;
        pixels_left_next   = pixels_left_reg;

        push                 = 1'b0;
        push_entry.kind      = tgard_pkg::ENTRY_PIXEL;
        push_entry.use_pal   = 1'b0;
        push_entry.index     = '0;
        push_entry.rgb       = '0;
        push_entry.alpha     = ALPHA_OPAQUE;
        push_entry.count     = 8'd1;
        push_entry.image_end = 1'b0;

        if (req.valid && req.ready)
        begin
            if (req.req_type == tgard_pkg::REQ_PALETTE)
            begin
                push             = 1'b1;
                push_entry.kind  = tgard_pkg::ENTRY_PAL_WRITE;
                push_entry.index = req.pal_index;
                push_entry.rgb   = {req.pal_red, req.pal_green, req.pal_blue};
            end
            else
            begin
                // image start: load pixel count, restart packet state
                if (pixels_left_next == 32'd0)
                begin
                    pixels_left_next   = cfg.pixel_total;
                    expect_header_next = 1'b1;
                    run_flag_next      = 1'b0;
                    packet_left_next   = '0;
                    byte_pos_next      = '0;
                    pixel_bytes_next   = '0;
                end

                case (cfg.depth_mode)
                    DEPTH_INDEX8: last_pos = 2'd0;
                    DEPTH_BGR24:  last_pos = 2'd2;
                    default:      last_pos = 2'd3;
                endcase
                shifted = 32'(b) << {byte_pos_next, 3'b000};

                if (pixels_left_next == 32'd0)
                begin
                    // empty image: byte dropped
                end
                else if (cfg.rle_enable && expect_header_next)
                begin
                    run_flag_next      = b[7];
                    packet_left_next   = {1'b0, b[6:0]} + 8'd1;
                    expect_header_next = 1'b0;
                end
                else if (byte_pos_next < last_pos)
                begin
                    pixel_bytes_next = pixel_bytes_next | shifted[23:0];
                    byte_pos_next    = byte_pos_next + 2'd1;
                end
                else
                begin
                    // pixel complete
                    case (cfg.depth_mode)
                        DEPTH_INDEX8:
                        begin
                            push_entry.use_pal = 1'b1;
                            push_entry.index   = b;
                        end
                        DEPTH_BGR24:
                        begin
                            if (byte_pos_next >= 2'd2)
                                pixel_bytes_next = {b, pixel_bytes_next[15:0]};
                            else
                                pixel_bytes_next = pixel_bytes_next | shifted[23:0];
                            push_entry.rgb = pixel_bytes_next;
                        end
                        default:
                        begin
                            if (byte_pos_next != 2'd3)
                                pixel_bytes_next = pixel_bytes_next | shifted[23:0];
                            push_entry.rgb   = pixel_bytes_next;
                            push_entry.alpha = (byte_pos_next == 2'd3) ? b : 8'd0;
                        end
                    endcase
                    byte_pos_next    = '0;
                    pixel_bytes_next = '0;

                    // run length and packet bookkeeping
                    if (cfg.rle_enable)
                    begin
                        if (run_flag_next)
                        begin
                            cnt = (packet_left_next == 8'd0) ? 8'd1 : packet_left_next;
                            packet_left_next   = '0;
                            expect_header_next = 1'b1;
                        end
                        else
                        begin
                            if (packet_left_next != 8'd0)
                                packet_left_next = packet_left_next - 8'd1;
                            if (packet_left_next == 8'd0)
                                expect_header_next = 1'b1;
                        end
                    end

                    // clip to the pixels left
                    if (32'(cnt) > pixels_left_next)
                        cnt = pixels_left_next[7:0];
                    pixels_left_next = pixels_left_next - 32'(cnt);

                    push                 = 1'b1;
                    push_entry.count     = cnt;
                    push_entry.image_end = (pixels_left_next == 32'd0);

                    if (pixels_left_next == 32'd0)
                    begin
                        expect_header_next = 1'b1;
                        run_flag_next      = 1'b0;
                        packet_left_next   = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            run_flag_reg      <= 1'b0;
            packet_left_reg   <= '0;
            byte_pos_reg      <= '0;
            pixel_bytes_reg   <= '0;
            pixels_left_reg   <= '0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            run_flag_reg      <= run_flag_next;
            packet_left_reg   <= packet_left_next;
            byte_pos_reg      <= byte_pos_next;
            pixel_bytes_reg   <= pixel_bytes_next;
            pixels_left_reg   <= pixels_left_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tgard_queue.sv =====
`default_nettype none

// Small FIFO between front and back
module tgard_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tgard_pkg::entry_t push_entry,
    output logic                   full,
    output logic                   q_valid,
    output tgard_pkg::entry_t      q_entry,
    input  wire logic              pop
);

    localparam int PTR_W = $clog2(tgard_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tgard_pkg::QUEUE_DEPTH + 1);

    tgard_pkg::entry_t slots_reg [tgard_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full    = (fill_reg == CNT_W'(tgard_pkg::QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_entry = slots_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tgard_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tgard_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ===== sv/tgard_back.sv =====
`default_nettype none

// Back end: palette memory, lookup and output register
module tgard_back #(
    parameter int PALETTE_DEPTH = tgard_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire tgard_pkg::entry_t q_entry,
    output logic                   pop,
    tgard_out_if.source            rsp
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    logic [23:0] pal_mem [PALETTE_DEPTH];

    logic        out_valid_reg, out_valid_next;
    logic        use_pal_reg;
    logic        pal_hit_reg;
    logic [23:0] pal_rd_reg;
    logic [7:0]  index_reg;
    logic [23:0] rgb_reg;
    logic [7:0]  alpha_reg;
    logic [7:0]  count_reg;
    logic        end_reg;

    logic        in_range;
    logic        pop_pixel;
    logic        pop_write;
    logic [23:0] color;

    assign in_range  = (32'(q_entry.index) < 32'(PALETTE_DEPTH));
    assign pop       = q_valid && (!out_valid_reg || rsp.ready);
    assign pop_pixel = pop && (q_entry.kind == tgard_pkg::ENTRY_PIXEL);
    assign pop_write = pop && (q_entry.kind == tgard_pkg::ENTRY_PAL_WRITE);

    // Output valid: loaded by a pixel, cleared once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_pixel)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Palette writes and registered lookups
    always_ff @(posedge clk)
    begin
        if (pop_write && in_range)
            pal_mem[q_entry.index[IDX_W-1:0]] <= q_entry.rgb;
        if (pop_pixel && q_entry.use_pal && in_range)
            pal_rd_reg <= pal_mem[q_entry.index[IDX_W-1:0]];
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop_pixel)
        begin
            use_pal_reg <= q_entry.use_pal;
            pal_hit_reg <= in_range;
            index_reg   <= q_entry.index;
            rgb_reg     <= q_entry.rgb;
            alpha_reg   <= q_entry.alpha;
            count_reg   <= q_entry.count;
            end_reg     <= q_entry.image_end;
        end
    end

    // Out-of-range palette reads give black
    assign color = use_pal_reg ? (pal_hit_reg ? pal_rd_reg : 24'd0) : rgb_reg;

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_index    = index_reg;
    assign rsp.out_red      = color[23:16];
    assign rsp.out_green    = color[15:8];
    assign rsp.out_blue     = color[7:0];
    assign rsp.out_alpha    = alpha_reg;
    assign rsp.repeat_count = count_reg;
    assign rsp.image_end    = end_reg;

endmodule

`default_nettype wire

// ===== sv/tga_rle_pixel_decoder.sv =====
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   req_type, pal_index, pal_red/green/blue, stream_byte
// rsp       out  valid/ready   out_index, out_red/green/blue, out_alpha,
//                              repeat_count, image_end
// cfg       in   cfg_we        cfg_index, cfg_data (no read-back)
//
// One item per cycle unless the queue is full; packet/pixel state updates per item.
// The item that completes a result passes through the queue, then the output register
// with its registered palette read.
// Reset clears control and configuration; palette contents are undefined until written.
// A four-entry queue absorbs output stalls; req.ready drops only when it is full.
`default_nettype none

module tga_rle_pixel_decoder #(
    parameter int PALETTE_DEPTH = tgard_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    tgard_in_if.sink         req,
    tgard_out_if.source      rsp
);

    localparam logic [1:0] REG_RLE_ENABLE  = 2'd0;
    localparam logic [1:0] REG_DEPTH_MODE  = 2'd1;
    localparam logic [1:0] REG_PIXEL_TOTAL = 2'd2;

    logic        rle_enable_reg;
    logic [1:0]  depth_mode_reg;
    logic [31:0] pixel_total_reg;

    tgard_pkg::cfg_t   cfg;
    tgard_pkg::entry_t push_entry;
    tgard_pkg::entry_t q_entry;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_enable_reg  <= 1'b0;
            depth_mode_reg  <= '0;
            pixel_total_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RLE_ENABLE:  rle_enable_reg  <= cfg_data[0];
                REG_DEPTH_MODE:  depth_mode_reg  <= cfg_data[1:0];
                REG_PIXEL_TOTAL: pixel_total_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.rle_enable  = rle_enable_reg;
    assign cfg.depth_mode  = depth_mode_reg;
    assign cfg.pixel_total = pixel_total_reg;

    tgard_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    tgard_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    tgard_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tgard_tb_pkg.sv =====
package tgard_tb_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RLE_ENABLE,
        CFG_DEPTH_MODE,
        CFG_PIXEL_TOTAL
    } cfg_reg_t;

    // Pixel depth codes; the spare code decodes like 32-bit BGRA
    typedef enum logic [1:0] {
        DEPTH_INDEXED,
        DEPTH_BGR,
        DEPTH_BGRA,
        DEPTH_SPARE
    } depth_code_t;

    // Largest image the pixel counter has to cover
    localparam logic [31:0] PIXEL_TOTAL_MAX = 32'd4294836225;

endpackage

// ===== tb/sv/tga_rle_pixel_decoder_checker.sv =====
module tga_rle_pixel_decoder_checker
    import tgard_pkg::*;
    import tgard_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    tgard_in_if         req,
    tgard_out_if        rsp,
    output int          pending_results,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] count;
        logic       image_end;
    } pixel_t;

    pixel_t expected_pixels[$];

    // Shadow configuration
    logic        cur_rle;
    depth_code_t cur_depth;
    logic [31:0] cur_total;

    // Shadow decoder state
    logic [23:0] palette [PALETTE_DEPTH_DEF];
    logic        want_header;
    logic        run_packet;
    logic [7:0]  packet_left;
    logic [1:0]  byte_pos;
    logic [23:0] pixel_bytes;
    logic [31:0] pixels_left;

    function automatic void restart_packet();
        want_header = 1'b1;
        run_packet  = 1'b0;
        packet_left = 8'd0;
        byte_pos    = 2'd0;
        pixel_bytes = 24'd0;
    endfunction

    // Advance the shadow decoder by one stream byte; returns 1 when a pixel
    // (or a whole run) completes
    function automatic bit decode_stream(input logic [7:0] b, output pixel_t px);
        int unsigned bpp;
        int unsigned cnt;
        logic [23:0] rgb;
        logic [7:0]  alpha;
        logic [7:0]  idx;
        px = '0;

        // new image starts on the first byte after the previous one ended
        if (pixels_left == 32'd0) begin
            pixels_left = cur_total;
            restart_packet();
            if (pixels_left == 32'd0)
                return 1'b0;
        end

        if (cur_rle && want_header) begin
            run_packet  = b[7];
            packet_left = {1'b0, b[6:0]} + 8'd1;
            want_header = 1'b0;
            return 1'b0;
        end

        case (cur_depth)
            DEPTH_INDEXED: bpp = 1;
            DEPTH_BGR:     bpp = 3;
            default:       bpp = 4;
        endcase

        // still collecting bytes of this pixel
        if (byte_pos + 1 < bpp) begin
            pixel_bytes = pixel_bytes | 24'(32'(b) << (8 * byte_pos));
            byte_pos    = byte_pos + 2'd1;
            return 1'b0;
        end

        idx   = 8'd0;
        alpha = 8'hFF;
        if (bpp == 1) begin
            idx = b;
            rgb = (b < PALETTE_DEPTH_DEF) ? palette[b] : 24'd0;
        end else if (bpp == 3) begin
            if (byte_pos >= 2)
                rgb = {b, pixel_bytes[15:0]};
            else
                rgb = pixel_bytes | 24'(32'(b) << (8 * byte_pos));
        end else begin
            if (byte_pos < 3)
                rgb = pixel_bytes | 24'(32'(b) << (8 * byte_pos));
            else
                rgb = pixel_bytes;
            alpha = (byte_pos >= 3) ? b : 8'd0;
        end
        byte_pos    = 2'd0;
        pixel_bytes = 24'd0;

        // repeat count from the packet, clipped to what is left of the image
        cnt = 1;
        if (cur_rle) begin
            if (run_packet) begin
                cnt = (packet_left == 8'd0) ? 1 : packet_left;
                packet_left = 8'd0;
                want_header = 1'b1;
            end else begin
                if (packet_left > 8'd0)
                    packet_left = packet_left - 8'd1;
                if (packet_left == 8'd0)
                    want_header = 1'b1;
            end
        end
        if (cnt > pixels_left)
            cnt = pixels_left;
        pixels_left = pixels_left - cnt;

        px.index     = idx;
        px.red       = rgb[23:16];
        px.green     = rgb[15:8];
        px.blue      = rgb[7:0];
        px.alpha     = alpha;
        px.count     = 8'(cnt);
        px.image_end = (pixels_left == 32'd0);

        if (pixels_left == 32'd0)
            restart_packet();
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Watch both channels and the config port
    always @(posedge clk or negedge rst_n) begin : monitor
        pixel_t px;
        pixel_t want;
        if (!rst_n) begin
            cur_rle     = 1'b0;
            cur_depth   = DEPTH_INDEXED;
            cur_total   = 32'd0;
            pixels_left = 32'd0;
            restart_packet();
            expected_pixels.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_RLE_ENABLE:  cur_rle   = cfg_data[0];
                    CFG_DEPTH_MODE:  cur_depth = depth_code_t'(cfg_data[1:0]);
                    CFG_PIXEL_TOTAL: cur_total = cfg_data;
                    default: ;
                endcase
            end

            // result side
            if (rsp.valid && rsp.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel result arrived with none pending");
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_index", want.index, rsp.out_index);
                    check_field("out_red", want.red, rsp.out_red);
                    check_field("out_green", want.green, rsp.out_green);
                    check_field("out_blue", want.blue, rsp.out_blue);
                    check_field("out_alpha", want.alpha, rsp.out_alpha);
                    check_field("repeat_count", want.count, rsp.repeat_count);
                    check_field("image_end", want.image_end, rsp.image_end);
                end
            end

            // request side
            if (req.valid && req.ready) begin
                if (req.req_type == REQ_PALETTE) begin
                    if (req.pal_index < PALETTE_DEPTH_DEF)
                        palette[req.pal_index] = {req.pal_red, req.pal_green, req.pal_blue};
                end else if (decode_stream(req.stream_byte, px)) begin
                    expected_pixels.push_back(px);
                end
            end
        end
        pending_results = expected_pixels.size();
    end

endmodule

// ===== tb/sv/tga_rle_pixel_decoder_test.sv =====
module tga_rle_pixel_decoder_test;
    import tgard_pkg::*;
    import tgard_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 120;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pal_index;
        logic [7:0] pal_red;
        logic [7:0] pal_green;
        logic [7:0] pal_blue;
        logic [7:0] stream_byte;
    } req_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          pending_results;
    int          fail_count;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          random_items;
    int          phase;
    req_item_t   stim_q[$];

    tgard_in_if  req_ch();
    tgard_out_if rsp_ch();

    tga_rle_pixel_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    tga_rle_pixel_decoder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Run limit
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic req_item_t stream_item(input logic [7:0] b);
        req_item_t it;
        it.req_type    = REQ_STREAM;
        it.pal_index   = 8'($urandom_range(0, 255));
        it.pal_red     = 8'($urandom_range(0, 255));
        it.pal_green   = 8'($urandom_range(0, 255));
        it.pal_blue    = 8'($urandom_range(0, 255));
        it.stream_byte = b;
        return it;
    endfunction

    function automatic req_item_t palette_item(input logic [7:0] idx, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b);
        req_item_t it;
        it.req_type    = REQ_PALETTE;
        it.pal_index   = idx;
        it.pal_red     = r;
        it.pal_green   = g;
        it.pal_blue    = b;
        it.stream_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic req_item_t random_palette_item();
        return palette_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // Offer one item with a random lead-in gap; returns at the accepting edge
    task automatic put_req(input req_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= it.req_type;
        req_ch.pal_index   <= it.pal_index;
        req_ch.pal_red     <= it.pal_red;
        req_ch.pal_green   <= it.pal_green;
        req_ch.pal_blue    <= it.pal_blue;
        req_ch.stream_byte <= it.stream_byte;
        do @(negedge clk); while (!req_ch.ready);
        @(posedge clk);
    endtask

    // Stop sending and let every pending pixel drain
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic rle, input depth_code_t depth,
                              input logic [31:0] total);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RLE_ENABLE;
        cfg_data  <= {31'd0, rle};
        @(posedge clk);
        cfg_index <= CFG_DEPTH_MODE;
        cfg_data  <= {30'd0, depth};
        @(posedge clk);
        cfg_index <= CFG_PIXEL_TOTAL;
        cfg_data  <= total;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_queue(input bit pause_mid);
        foreach (stim_q[i]) begin
            // one hold-off until every pending pixel is out
            if (pause_mid && i == stim_q.size() / 2) begin
                req_ch.valid <= 1'b0;
                do @(negedge clk); while (pending_results != 0);
                @(posedge clk);
            end
            put_req(stim_q[i]);
        end
    endtask

    // Well-formed packet stream covering one image, palette writes mixed in
    task automatic queue_image(input logic rle, input depth_code_t depth, input int total);
        int left;
        int n;
        int bpp;
        bit run;
        bpp  = (depth == DEPTH_INDEXED) ? 1 : (depth == DEPTH_BGR) ? 3 : 4;
        left = total;
        while (left > 0) begin
            if (rle) begin
                run = $urandom_range(0, 1);
                if (run)
                    n = ($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
                else
                    n = $urandom_range(1, 6);
                stim_q.push_back(stream_item(8'((run ? 128 : 0) + n - 1)));
                repeat ((run ? 1 : n) * bpp)
                    stim_q.push_back(stream_item(8'($urandom_range(0, 255))));
            end else begin
                n = 1;
                repeat (bpp) stim_q.push_back(stream_item(8'($urandom_range(0, 255))));
            end
            left -= n;
            if ($urandom_range(9) == 0)
                stim_q.push_back(random_palette_item());
        end
    endtask

    initial begin : stimulus
        logic        rle;
        depth_code_t depth;
        int          total;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_RLE_ENABLE;
        cfg_data           = 32'd0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_PALETTE;
        req_ch.pal_index   = 8'd0;
        req_ch.pal_red     = 8'd0;
        req_ch.pal_green   = 8'd0;
        req_ch.pal_blue    = 8'd0;
        req_ch.stream_byte = 8'd0;
        src_idle_pct       = 0;
        snk_stall_pct      = 0;
        random_items       = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty image after reset: bytes are dropped
        put_req(stream_item(8'h00));
        put_req(stream_item(8'hFF));
        put_req(palette_item(8'h00, 8'hFF, 8'h00, 8'hFF));
        put_req(palette_item(8'hFF, 8'h00, 8'hFF, 8'h00));
        put_req(palette_item(8'hAA, 8'h55, 8'hAA, 8'h5A));

        // Raw indexed pixels through the palette
        settle();
        set_config(1'b0, DEPTH_INDEXED, 32'd3);
        put_req(stream_item(8'h00));
        put_req(stream_item(8'hFF));
        put_req(stream_item(8'hAA));

        // RLE BGR: run of three, then a raw packet of two
        settle();
        set_config(1'b1, DEPTH_BGR, 32'd5);
        put_req(stream_item(8'h82));
        put_req(stream_item(8'h00));
        put_req(stream_item(8'hFF));
        put_req(stream_item(8'h00));
        put_req(stream_item(8'h01));
        put_req(stream_item(8'hFF));
        put_req(stream_item(8'h00));
        put_req(stream_item(8'hFF));
        put_req(stream_item(8'h12));
        put_req(stream_item(8'h34));
        put_req(stream_item(8'h56));

        // Longest run clipped to a short image, BGRA
        settle();
        set_config(1'b1, DEPTH_BGRA, 32'd4);
        put_req(stream_item(8'hFF));
        put_req(stream_item(8'h01));
        put_req(stream_item(8'h02));
        put_req(stream_item(8'h03));
        put_req(stream_item(8'h80));

        // Depth shrinks mid-pixel, then the spare depth code
        settle();
        set_config(1'b0, DEPTH_BGRA, 32'd2);
        put_req(stream_item(8'h11));
        put_req(stream_item(8'h22));
        settle();
        set_config(1'b0, DEPTH_BGR, 32'd2);
        put_req(stream_item(8'h33));
        settle();
        set_config(1'b0, DEPTH_SPARE, 32'd2);
        put_req(stream_item(8'hC0));
        put_req(stream_item(8'h3F));
        put_req(stream_item(8'hF0));
        put_req(stream_item(8'h0F));

        // Fill the whole palette so any index is safe to read from here on
        src_idle_pct  = 14;
        snk_stall_pct = 14;
        for (int i = 0; i < PALETTE_DEPTH_DEF; i++)
            put_req(palette_item(8'(i), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));

        // Random phases; every idling pattern runs at least once
        phase = 0;
        while (random_items < RANDOM_ITEMS || phase < 4) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
                default: begin src_idle_pct = 14; snk_stall_pct = 14; end
            endcase
            rle   = $urandom_range(0, 1);
            depth = depth_code_t'($urandom_range(0, 3));
            total = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40);
            settle();
            set_config(rle, depth, 32'(total));

            stim_q.delete();
            if ($urandom_range(4) == 0 || total == 0) begin
                // noise and broken packets
                repeat ($urandom_range(8, 20)) begin
                    if ($urandom_range(3) == 0)
                        stim_q.push_back(random_palette_item());
                    else
                        stim_q.push_back(stream_item(8'($urandom_range(0, 255))));
                end
            end else begin
                queue_image(rle, depth, total);
            end
            random_items += stim_q.size();
            send_queue(phase == 1);
            phase++;
        end

        // Largest image: drain pending pixels, then load the maximum count
        src_idle_pct  = 14;
        snk_stall_pct = 14;
        settle();
        set_config(1'b0, DEPTH_INDEXED, PIXEL_TOTAL_MAX);
        repeat (48) put_req(stream_item(8'($urandom_range(0, 255))));
        settle();
        set_config(1'b1, DEPTH_BGRA, PIXEL_TOTAL_MAX);
        stim_q.delete();
        stim_q.push_back(stream_item(8'hFF));
        repeat (4) stim_q.push_back(stream_item(8'($urandom_range(0, 255))));
        stim_q.push_back(stream_item(8'h00));
        repeat (4) stim_q.push_back(stream_item(8'($urandom_range(0, 255))));
        stim_q.push_back(stream_item(8'h80));
        repeat (4) stim_q.push_back(stream_item(8'($urandom_range(0, 255))));
        send_queue(1'b0);

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
